[design/tbds_pkg.sv]
package tbds_pkg;

  // fixed constants of the shaper
  localparam int unsigned INIT_TOKENS = 1500;
  localparam int unsigned MAX_RESULTS = 32;
  localparam int unsigned MS_SCALE    = 1000;
  localparam int unsigned HALF_MS_DIV = 2000;
  localparam int unsigned FREQ_RESET  = 10000000;
  localparam int unsigned DIV_STEPS   = 96;

  // result kinds
  typedef enum logic [2:0] {
    KIND_ACCEPTED = 3'd0,
    KIND_LOST     = 3'd1,
    KIND_BUFFER   = 3'd2,
    KIND_FULL     = 3'd3,
    KIND_RELEASED = 3'd4
  } kind_t;

  // configuration register indexes
  typedef enum logic [2:0] {
    CFG_RATE      = 3'd0,
    CFG_LATENCY   = 3'd1,
    CFG_BUF_LIMIT = 3'd2,
    CFG_LOSS      = 3'd3,
    CFG_FREQ      = 3'd4
  } cfg_idx_t;

  // controller to datapath commands
  typedef struct packed {
    logic load;
    logic enq_do;
    logic el_cap;
    logic latch_time;
    logic mul_lo;
    logic mul_hi;
    logic mul_thr;
    logic div_init;
    logic div_step;
    logic tok_upd;
    logic mv_chk;
    logic rel_init;
    logic rel_dif;
    logic rel_mul;
    logic rel_adv;
    logic em_init;
    logic em_rd;
    logic em_out;
  } cmd_t;

  // datapath to controller status
  typedef struct packed {
    logic stored_zero;
    logic time_valid;
    logic div_last;
    logic mv_done;
    logic mv_block;
    logic scan_stop;
    logic rel_ok;
    logic scan_zero;
    logic res_last;
  } stat_t;

endpackage

[design/tbds_ram.sv]
module tbds_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 32
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem_r [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  // one write port, one registered read port
  always_ff @(posedge clk) begin
    if (we) begin
      mem_r[waddr] <= wdata;
    end
    rdata_r <= mem_r[raddr];
  end

  assign rdata = rdata_r;

endmodule

[design/tbds_datapath.sv]
module tbds_datapath import tbds_pkg::*; #(
  parameter int QUEUE_DEPTH = 32,
  parameter int TIME_WIDTH  = 48
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  cfg_we,
  input  logic [2:0]            cfg_index,
  input  logic [31:0]           cfg_data,
  input  logic [15:0]           in_packet_tag,
  input  logic [15:0]           in_packet_length,
  input  logic [13:0]           in_loss_draw,
  input  logic [TIME_WIDTH-1:0] in_now_time,
  input  cmd_t                  cmd,
  output stat_t                 stat,
  output logic [2:0]            res_kind,
  output logic [15:0]           res_tag,
  output logic [15:0]           res_length,
  output logic                  res_last,
  output logic                  res_qa
);

  localparam int PW   = $clog2(QUEUE_DEPTH);
  localparam int CW   = $clog2(QUEUE_DEPTH + 1);
  localparam int XW   = TIME_WIDTH + 11;
  localparam int CMPW = (XW > 48) ? XW : 48;

  // ceil(2^35 / 125): exact floor division by 125 for 28-bit operands
  localparam logic [28:0] HALF_MS_RECIP = 29'd274877907;

  // configuration
  logic [31:0] rate_r, limit_r, freq_r;
  logic [15:0] lat_r;
  logic [13:0] loss_r;

  // latched request
  logic [15:0]           tag_in_r, len_in_r;
  logic [13:0]           draw_r;
  logic [TIME_WIDTH-1:0] now_r;

  // queue state
  logic [PW-1:0]         head_r, wait_r, tail_r;
  logic [CW-1:0]         stored_r, delayed_r;
  logic [63:0]           tok_r;
  logic [31:0]           wb_r;
  logic [TIME_WIDTH-1:0] last_time_r;
  logic                  tvalid_r;

  // arithmetic
  logic [TIME_WIDTH-1:0] el_r, d_r;
  logic [95:0]           prod_r, dq_r;
  logic [47:0]           thr_r;
  logic [31:0]           rem_r, cq_r;
  logic [6:0]            div_cnt_r;
  logic [XW-1:0]         x_r;

  // release walk
  logic [PW-1:0] scan_ptr_r;
  logic [CW-1:0] scan_cnt_r, em_left_r;
  logic          qa_r;

  // results
  kind_t       res_kind_r;
  logic [15:0] res_tag_r, res_len_r;
  logic        res_last_r, res_qa_r;

  // memories
  logic [31:0]           data_rd;
  logic [TIME_WIDTH-1:0] stamp_rd;
  logic                  data_we, stamp_we;
  logic [PW-1:0]         data_raddr;

  function automatic logic [PW-1:0] nxt_ptr(input logic [PW-1:0] p);
    return (p == PW'(QUEUE_DEPTH - 1)) ? '0 : p + 1'b1;
  endfunction

  logic [31:0] freq_eff;
  assign freq_eff = (freq_r == 32'd0) ? 32'd1 : freq_r;

  // shared 32x32 multiplier
  logic [63:0] el64, mul_p;
  logic [31:0] mul_a, mul_b;
  assign el64  = 64'(el_r);
  assign mul_a = cmd.mul_thr ? {16'd0, lat_r} : (cmd.mul_hi ? el64[63:32] : el64[31:0]);
  assign mul_b = cmd.mul_thr ? freq_eff : rate_r;
  assign mul_p = 64'(mul_a) * 64'(mul_b);

  // one bit a step divider by the counter frequency
  logic [32:0] trial;
  logic        ge;
  logic [31:0] rem_n;
  assign trial = {rem_r, dq_r[95]};
  assign ge    = trial >= {1'b0, freq_eff};
  assign rem_n = ge ? 32'(trial - {1'b0, freq_eff}) : trial[31:0];

  // rounding offset freq / 2000 as (freq / 16) / 125 by reciprocal
  logic [56:0] half_prod;
  assign half_prod = 57'(freq_eff[31:4]) * 57'(HALF_MS_RECIP);

  // token refill with saturation and idle cap
  logic [63:0] add64, tok_sat, tok_cap;
  logic [64:0] sum65;
  assign add64   = (|dq_r[95:64]) ? '1 : dq_r[63:0];
  assign sum65   = {1'b0, tok_r} + {1'b0, add64};
  assign tok_sat = sum65[64] ? '1 : sum65[63:0];
  assign tok_cap = (stored_r == delayed_r && tok_sat > 64'(INIT_TOKENS)) ?
                   64'(INIT_TOKENS) : tok_sat;

  // move check on the packet at the waiting pointer
  logic [15:0] mv_len;
  logic        mv_block;
  assign mv_len   = data_rd[15:0];
  assign mv_block = (rate_r != 32'd0) && (tok_r < 64'(mv_len));

  // enqueue checks
  logic        lost, over, full, take;
  logic [32:0] wb_sum;
  assign wb_sum = {1'b0, wb_r} + 33'(len_in_r);
  assign lost   = (loss_r != 14'd0) && (draw_r < loss_r);
  assign over   = (limit_r != 32'd0) && (wb_sum > {1'b0, limit_r});
  assign full   = stored_r == CW'(QUEUE_DEPTH);
  assign take   = !lost && !over && !full;

  // configuration writes
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      rate_r  <= '0;
      lat_r   <= '0;
      limit_r <= '0;
      loss_r  <= '0;
      freq_r  <= 32'(FREQ_RESET);
    end else if (cfg_we) begin
      unique case (cfg_index)
        CFG_RATE:      rate_r  <= cfg_data;
        CFG_LATENCY:   lat_r   <= cfg_data[15:0];
        CFG_BUF_LIMIT: limit_r <= cfg_data;
        CFG_LOSS:      loss_r  <= cfg_data[13:0];
        CFG_FREQ:      freq_r  <= cfg_data;
        default: ;
      endcase
    end
  end

  // queue control state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      head_r      <= '0;
      wait_r      <= '0;
      tail_r      <= '0;
      stored_r    <= '0;
      delayed_r   <= '0;
      tok_r       <= 64'(INIT_TOKENS);
      wb_r        <= '0;
      last_time_r <= '0;
      tvalid_r    <= 1'b0;
    end else begin
      if (cmd.enq_do && take) begin
        tail_r   <= nxt_ptr(tail_r);
        stored_r <= stored_r + 1'b1;
        wb_r     <= wb_sum[31:0];
      end
      if (cmd.latch_time) begin
        last_time_r <= now_r;
        tvalid_r    <= 1'b1;
      end
      if (cmd.tok_upd) begin
        tok_r       <= tok_cap;
        last_time_r <= now_r;
      end
      if (cmd.mv_chk && !mv_block) begin
        tok_r     <= (tok_r >= 64'(mv_len)) ? tok_r - 64'(mv_len) : '0;
        wb_r      <= (wb_r >= 32'(mv_len)) ? wb_r - 32'(mv_len) : '0;
        wait_r    <= nxt_ptr(wait_r);
        delayed_r <= delayed_r + 1'b1;
      end
      if (cmd.em_out) begin
        head_r    <= nxt_ptr(head_r);
        stored_r  <= stored_r - 1'b1;
        delayed_r <= delayed_r - 1'b1;
      end
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    if (cmd.load) begin
      tag_in_r <= in_packet_tag;
      len_in_r <= in_packet_length;
      draw_r   <= in_loss_draw;
      now_r    <= in_now_time;
    end
    if (cmd.el_cap) begin
      el_r <= now_r - last_time_r;
    end
    if (cmd.mul_lo) begin
      prod_r <= 96'(mul_p);
    end
    if (cmd.mul_hi) begin
      prod_r <= prod_r + {mul_p, 32'd0};
    end
    if (cmd.mul_thr) begin
      thr_r <= mul_p[47:0];
    end
    if (cmd.div_init) begin
      dq_r      <= prod_r;
      rem_r     <= '0;
      cq_r      <= 32'(half_prod[56:35]);
      div_cnt_r <= '0;
    end
    if (cmd.div_step) begin
      dq_r      <= {dq_r[94:0], ge};
      rem_r     <= rem_n;
      div_cnt_r <= div_cnt_r + 1'b1;
    end
    if (cmd.rel_init) begin
      scan_ptr_r <= head_r;
      scan_cnt_r <= '0;
    end
    if (cmd.rel_dif) begin
      d_r <= now_r - stamp_rd;
    end
    if (cmd.rel_mul) begin
      x_r <= XW'(d_r) * XW'(MS_SCALE) + XW'(cq_r);
    end
    if (cmd.rel_adv) begin
      scan_ptr_r <= nxt_ptr(scan_ptr_r);
      scan_cnt_r <= scan_cnt_r + 1'b1;
    end
    if (cmd.em_init) begin
      em_left_r <= scan_cnt_r;
      qa_r      <= stored_r != scan_cnt_r;
    end
    if (cmd.enq_do) begin
      res_tag_r  <= tag_in_r;
      res_len_r  <= len_in_r;
      res_last_r <= 1'b1;
      res_qa_r   <= take || (stored_r != '0);
      if (lost) begin
        res_kind_r <= KIND_LOST;
      end else if (over) begin
        res_kind_r <= KIND_BUFFER;
      end else if (full) begin
        res_kind_r <= KIND_FULL;
      end else begin
        res_kind_r <= KIND_ACCEPTED;
      end
    end
    if (cmd.em_out) begin
      res_kind_r <= KIND_RELEASED;
      res_tag_r  <= data_rd[31:16];
      res_len_r  <= data_rd[15:0];
      res_last_r <= em_left_r == CW'(1);
      res_qa_r   <= qa_r;
      em_left_r  <= em_left_r - 1'b1;
    end
  end

  // packet store and delay stamps
  assign data_we    = cmd.enq_do && take;
  assign stamp_we   = cmd.mv_chk && !mv_block;
  assign data_raddr = cmd.em_rd ? head_r : wait_r;

  tbds_ram #(.WIDTH(32), .DEPTH(QUEUE_DEPTH)) u_data_ram (
    .clk   (clk),
    .we    (data_we),
    .waddr (tail_r),
    .wdata ({tag_in_r, len_in_r}),
    .raddr (data_raddr),
    .rdata (data_rd)
  );

  tbds_ram #(.WIDTH(TIME_WIDTH), .DEPTH(QUEUE_DEPTH)) u_stamp_ram (
    .clk   (clk),
    .we    (stamp_we),
    .waddr (wait_r),
    .wdata (now_r),
    .raddr (scan_ptr_r),
    .rdata (stamp_rd)
  );

  // status back to the controller
  assign stat.stored_zero = stored_r == '0;
  assign stat.time_valid  = tvalid_r;
  assign stat.div_last    = div_cnt_r == 7'(DIV_STEPS - 1);
  assign stat.mv_done     = delayed_r == stored_r;
  assign stat.mv_block    = mv_block;
  assign stat.scan_stop   = (scan_cnt_r == delayed_r) || (32'(scan_cnt_r) == MAX_RESULTS);
  assign stat.rel_ok      = CMPW'(x_r) >= CMPW'(thr_r);
  assign stat.scan_zero   = scan_cnt_r == '0;
  assign stat.res_last    = res_last_r;

  assign res_kind   = res_kind_r;
  assign res_tag    = res_tag_r;
  assign res_length = res_len_r;
  assign res_last   = res_last_r;
  assign res_qa     = res_qa_r;

endmodule

[design/tbds_ctrl.sv]
module tbds_ctrl import tbds_pkg::*; (
  input  logic  clk,
  input  logic  rst_n,
  input  logic  start,
  input  logic  in_mode,
  input  stat_t stat,
  output cmd_t  cmd,
  output logic  busy,
  output logic  out_valid
);

  typedef enum logic [4:0] {
    S_IDLE, S_ENQ, S_SHOW, S_TCHK, S_MUL_LO, S_MUL_HI, S_MUL_THR, S_DIV_INIT,
    S_DIV, S_TOK, S_MV_RD, S_MV_CHK, S_REL_INIT, S_REL_RD, S_REL_DIF,
    S_REL_MUL, S_REL_CMP, S_EM_INIT, S_EM_RD, S_EM_OUT
  } state_t;

  state_t state_r, state_nxt;
  logic   busy_r, valid_r;

  // next state and commands
  always_comb begin
    cmd       = '0;
    state_nxt = state_r;
    unique case (state_r)
      S_IDLE: begin
        if (start) begin
          cmd.load  = 1'b1;
          state_nxt = in_mode ? S_TCHK : S_ENQ;
        end
      end
      S_ENQ: begin
        cmd.enq_do = 1'b1;
        state_nxt  = S_SHOW;
      end
      S_SHOW: begin
        state_nxt = stat.res_last ? S_IDLE : S_EM_RD;
      end
      S_TCHK: begin
        cmd.el_cap = 1'b1;
        if (stat.stored_zero) begin
          state_nxt = S_IDLE;
        end else if (!stat.time_valid) begin
          cmd.latch_time = 1'b1;
          state_nxt      = S_IDLE;
        end else begin
          state_nxt = S_MUL_LO;
        end
      end
      S_MUL_LO: begin
        cmd.mul_lo = 1'b1;
        state_nxt  = S_MUL_HI;
      end
      S_MUL_HI: begin
        cmd.mul_hi = 1'b1;
        state_nxt  = S_MUL_THR;
      end
      S_MUL_THR: begin
        cmd.mul_thr = 1'b1;
        state_nxt   = S_DIV_INIT;
      end
      S_DIV_INIT: begin
        cmd.div_init = 1'b1;
        state_nxt    = S_DIV;
      end
      S_DIV: begin
        cmd.div_step = 1'b1;
        if (stat.div_last) begin
          state_nxt = S_TOK;
        end
      end
      S_TOK: begin
        cmd.tok_upd = 1'b1;
        state_nxt   = S_MV_RD;
      end
      S_MV_RD: begin
        state_nxt = stat.mv_done ? S_REL_INIT : S_MV_CHK;
      end
      S_MV_CHK: begin
        cmd.mv_chk = 1'b1;
        state_nxt  = stat.mv_block ? S_REL_INIT : S_MV_RD;
      end
      S_REL_INIT: begin
        cmd.rel_init = 1'b1;
        state_nxt    = S_REL_RD;
      end
      S_REL_RD: begin
        state_nxt = stat.scan_stop ? S_EM_INIT : S_REL_DIF;
      end
      S_REL_DIF: begin
        cmd.rel_dif = 1'b1;
        state_nxt   = S_REL_MUL;
      end
      S_REL_MUL: begin
        cmd.rel_mul = 1'b1;
        state_nxt   = S_REL_CMP;
      end
      S_REL_CMP: begin
        if (stat.rel_ok) begin
          cmd.rel_adv = 1'b1;
          state_nxt   = S_REL_RD;
        end else begin
          state_nxt = S_EM_INIT;
        end
      end
      S_EM_INIT: begin
        if (stat.scan_zero) begin
          state_nxt = S_IDLE;
        end else begin
          cmd.em_init = 1'b1;
          state_nxt   = S_EM_RD;
        end
      end
      S_EM_RD: begin
        cmd.em_rd = 1'b1;
        state_nxt = S_EM_OUT;
      end
      S_EM_OUT: begin
        cmd.em_out = 1'b1;
        state_nxt  = S_SHOW;
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  // state and registered handshake outputs
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      busy_r  <= 1'b0;
      valid_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      busy_r  <= state_nxt != S_IDLE;
      valid_r <= state_nxt == S_SHOW;
    end
  end

  assign busy      = busy_r;
  assign out_valid = valid_r;

endmodule

[design/token_bucket_delay_shaper.sv]
// Single-queue token bucket shaper with a minimum delay stage.
// Requests: raise start with the fields valid; a request is taken at a
// clock edge where start is high and busy is low. in_mode 0 enqueues a
// packet, in_mode 1 is a timer tick carrying in_now_time.
// Results: each result is shown for one cycle with out_valid high; the
// receiver cannot stall and must take it in that cycle. out_last marks
// the final result of a request.
// Enqueue: one result, registered in S_ENQ and shown in S_SHOW; busy falls
// after it is shown, so the next request can then be taken.
// Tick: no result on an empty queue or on the first tick.
// Otherwise the refill runs a 96-step one-bit divider by the counter
// frequency, then moves packets into the delay stage while tokens allow,
// checks delayed packets for release (at most 32) and shows each
// released packet on its own strobe.
// Configuration: cfg_we, cfg_index and cfg_data write a register at once;
// write only while busy is low.
// Reset (synchronous, rst_n low): queue empty, 1500 tokens, time not
// latched, registers at their defaults. The packet store needs no clear.
module token_bucket_delay_shaper import tbds_pkg::*; #(
  parameter int QUEUE_DEPTH = 32,
  parameter int TIME_WIDTH  = 48
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  start,
  output logic                  busy,
  input  logic                  in_mode,
  input  logic [15:0]           in_packet_tag,
  input  logic [15:0]           in_packet_length,
  input  logic [13:0]           in_loss_draw,
  input  logic [TIME_WIDTH-1:0] in_now_time,
  output logic                  out_valid,
  output logic [2:0]            out_kind,
  output logic [15:0]           out_tag,
  output logic [15:0]           out_length,
  output logic                  out_last,
  output logic                  out_queue_active,
  input  logic                  cfg_we,
  input  logic [2:0]            cfg_index,
  input  logic [31:0]           cfg_data
);

  cmd_t  cmd;
  stat_t stat;

  tbds_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .start     (start),
    .in_mode   (in_mode),
    .stat      (stat),
    .cmd       (cmd),
    .busy      (busy),
    .out_valid (out_valid)
  );

  tbds_datapath #(.QUEUE_DEPTH(QUEUE_DEPTH), .TIME_WIDTH(TIME_WIDTH)) u_dp (
    .clk              (clk),
    .rst_n            (rst_n),
    .cfg_we           (cfg_we),
    .cfg_index        (cfg_index),
    .cfg_data         (cfg_data),
    .in_packet_tag    (in_packet_tag),
    .in_packet_length (in_packet_length),
    .in_loss_draw     (in_loss_draw),
    .in_now_time      (in_now_time),
    .cmd              (cmd),
    .stat             (stat),
    .res_kind         (out_kind),
    .res_tag          (out_tag),
    .res_length       (out_length),
    .res_last         (out_last),
    .res_qa           (out_queue_active)
  );

  // results only appear inside a request
  a_valid_busy: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> busy) else $error("result outside a request");

  // every result is a single-cycle strobe
  a_strobe: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |=> !out_valid) else $error("result strobe longer than one cycle");

  // the last result ends the request
  a_last_idle: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_last |=> !busy) else $error("busy after last result");

  // a taken request always makes the block busy
  a_take_busy: assert property (@(posedge clk) disable iff (!rst_n)
    start && !busy |=> busy) else $error("request taken without going busy");

  // enqueue results are single and final
  a_enq_last: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && (out_kind != KIND_RELEASED) |-> out_last)
    else $error("enqueue result not marked last");

endmodule
